>>> hw/rtl/circular_deque_defines.svh
// circular_deque_defines.svh: assertion macros for the deque checker.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// Clocked check that is switched off while reset is high
`define DQ_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("circular_deque check failed");

// Clocked check that also holds across reset
`define DQ_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("circular_deque check failed");

`endif

>>> hw/rtl/dq_pkg.sv
// dq_pkg: widths, action codes and cell control type for circular_deque.
// Used by dq_cell, circular_deque and dq_checker; depends on nothing.
package dq_pkg;

  localparam int MAX_ITEMS = 15;
  localparam int WORD_W    = 32;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int ACT_W     = 3;

  localparam logic [CNT_W-1:0]  CAP_RESET = CNT_W'(MAX_ITEMS);
  localparam logic [WORD_W-1:0] EMPTY_WORD = '1;

  localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_REAR  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_DEL_FRONT = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DEL_REAR  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_NOP       = 3'd4;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT,
    CELL_LOAD
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
  } cell_ctl_t;

endpackage

>>> hw/rtl/circular_deque.sv
// circular_deque: top level of the double-ended queue of 32-bit words.
// Depends on dq_pkg and dq_cell.
//
// Usage:
//   Input channel in_valid/in_ready carries one word per item: an action
//   (insert front, insert rear, delete front, delete rear, no operation)
//   and a value used by the inserts. Output channel out_valid/out_ready
//   returns one word per item: accepted, front_value, rear_value (all ones
//   when empty), is_empty and is_full, as they stand after the action.
//   The words sit in a row of cells with the front in cell 0; an insert at
//   the front or a delete at the front shifts the whole row by one cell,
//   a rear insert loads the cell at the fill count.
//   Result: registered; it shows in the cycle after accept.
//   Throughput: one item per cycle while results are taken (see Stall).
//   Stall: while a result waits unaccepted, in_ready is low; in_ready is
//   high again in the cycle the result is taken.
//   Config: cfg_we/cfg_wdata set the capacity (0 to 15) and empty the
//   deque; write it only while no item is in flight.
//   Reset: synchronous; empties the deque, capacity back to 15, no result pending.
module circular_deque import dq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ACT_W-1:0]         action,
  input  logic signed [WORD_W-1:0] value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     accepted,
  output logic signed [WORD_W-1:0] front_value,
  output logic signed [WORD_W-1:0] rear_value,
  output logic                     is_empty,
  output logic                     is_full,
  input  logic                     cfg_we,
  input  logic [CNT_W-1:0]         cfg_wdata
);

  logic [CNT_W-1:0]  capacity;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [WORD_W-1:0] cell_word [MAX_ITEMS];
  cell_ctl_t         cell_ctl  [MAX_ITEMS];

  logic              fire;
  logic              cur_empty;
  logic              cur_full;
  logic              ok;
  logic [WORD_W-1:0] rear_cur;
  logic [WORD_W-1:0] rear_prev;
  logic [WORD_W-1:0] front_after;
  logic [WORD_W-1:0] rear_after;

  assign in_ready  = !out_valid || out_ready;
  assign fire      = in_valid && in_ready;
  assign cur_empty = (count == '0);
  assign cur_full  = (count == capacity);

  // action decode: is it legal and where does the fill count go
  always_comb begin
    ok         = 1'b0;
    count_next = count;
    unique case (action)
      ACT_INS_FRONT, ACT_INS_REAR: begin
        ok         = !cur_full;
        count_next = cur_full ? count : count + CNT_W'(1);
      end
      ACT_DEL_FRONT, ACT_DEL_REAR: begin
        ok         = !cur_empty;
        count_next = cur_empty ? count : count - CNT_W'(1);
      end
      default: begin
        ok         = 1'b0;
        count_next = count;
      end
    endcase
  end

  // rear word now and the one before it, picked by the fill count
  always_comb begin
    rear_cur  = '0;
    rear_prev = '0;
    for (int i = 0; i < MAX_ITEMS; i++) begin
      if ({1'b0, count} == (CNT_W + 1)'(i + 1)) rear_cur  = rear_cur  | cell_word[i];
      if ({1'b0, count} == (CNT_W + 1)'(i + 2)) rear_prev = rear_prev | cell_word[i];
    end
  end

  // front and rear words after the action
  always_comb begin
    front_after = cell_word[0];
    rear_after  = rear_cur;
    if (ok) begin
      unique case (action)
        ACT_INS_FRONT: begin
          front_after = value;
          rear_after  = cur_empty ? value : rear_cur;
        end
        ACT_INS_REAR: begin
          front_after = cur_empty ? value : cell_word[0];
          rear_after  = value;
        end
        ACT_DEL_FRONT: front_after = cell_word[1];
        ACT_DEL_REAR:  rear_after  = rear_prev;
        default: begin
          front_after = cell_word[0];
          rear_after  = rear_cur;
        end
      endcase
    end
  end

  // per-cell control: shift the row or load one slot
  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      cell_ctl[i].op = CELL_HOLD;
      if (fire && ok) begin
        unique case (action)
          ACT_INS_FRONT: cell_ctl[i].op = CELL_FROM_LEFT;
          ACT_INS_REAR: begin
            if ({1'b0, count} == (CNT_W + 1)'(i)) cell_ctl[i].op = CELL_LOAD;
          end
          ACT_DEL_FRONT: cell_ctl[i].op = CELL_FROM_RIGHT;
          default:       cell_ctl[i].op = CELL_HOLD;
        endcase
      end
    end
  end

  // row of cells; cell 0 is the front, new front words enter from the left
  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = value;
    end else begin : g_mid
      assign left_w = cell_word[g-1];
    end
    if (g == MAX_ITEMS - 1) begin : g_last
      assign right_w = cell_word[g];
    end else begin : g_inner
      assign right_w = cell_word[g+1];
    end
    dq_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[g]),
      .from_left  (left_w),
      .from_right (right_w),
      .load_word  (value),
      .word       (cell_word[g])
    );
  end

  // capacity and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      count    <= '0;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
      count    <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      accepted    <= ok;
      is_empty    <= (count_next == '0);
      is_full     <= (count_next == capacity);
      front_value <= (count_next == '0) ? EMPTY_WORD : front_after;
      rear_value  <= (count_next == '0) ? EMPTY_WORD : rear_after;
    end
  end

endmodule

>>> hw/rtl/dq_cell.sv
// dq_cell: one storage slot of the deque row; takes a word from either
// neighbor or a fresh word. Depends on dq_pkg.
module dq_cell import dq_pkg::*; (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [WORD_W-1:0] from_left,
  input  logic [WORD_W-1:0] from_right,
  input  logic [WORD_W-1:0] load_word,
  output logic [WORD_W-1:0] word
);

  // slot register, no reset: only read after an insert wrote it
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_HOLD:       word <= word;
      CELL_FROM_LEFT:  word <= from_left;
      CELL_FROM_RIGHT: word <= from_right;
      CELL_LOAD:       word <= load_word;
      default:         word <= word;
    endcase
  end

endmodule

>>> hw/rtl/dq_checker.sv
// dq_checker: port-level checks on circular_deque, bound to the top level.
// Depends on dq_pkg and circular_deque_defines.svh.
`include "circular_deque_defines.svh"

module dq_checker import dq_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic                     accepted,
  input logic signed [WORD_W-1:0] front_value,
  input logic signed [WORD_W-1:0] rear_value,
  input logic                     is_empty,
  input logic                     is_full
);

  // whole result word, for the hold check
  logic [2*WORD_W+2:0] result_word;
  assign result_word = {accepted, front_value, rear_value, is_empty, is_full};

  // a stalled result word stays put
  `DQ_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(result_word))

  // every accepted word gives a result in the next cycle
  `DQ_ASSERT(a_in_to_out, clk, rst, in_valid && in_ready |=> out_valid)

  // an empty deque reports all ones at both ends
  `DQ_ASSERT(a_empty_words, clk, rst, out_valid && is_empty |-> (&front_value) && (&rear_value))

  // empty and full together means zero capacity, where nothing succeeds
  `DQ_ASSERT(a_zero_cap, clk, rst, out_valid && is_empty && is_full |-> !accepted)

  // reset drops any pending result
  `DQ_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !out_valid)

endmodule

bind circular_deque dq_checker u_dq_checker (.*);
